// File: rtl/hta_pkg.sv
package hta_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int ID_W        = 32;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
   // Ids 1 .. TABLE_SLOTS+1 are the only ones that can matter for generate.
   localparam int USED_N      = TABLE_SLOTS + 1;
   localparam int USED_IW     = $clog2(USED_N);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_GENERATE = 2'd0,
      OP_DELETE   = 2'd1,
      OP_BIND     = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_DONE
   } state_type;

   // A classified command as it travels from the front end to the engine.
   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     id;
      logic                id_zero;
      logic                bind_err;
      logic                scan;
   } cmd_type;

endpackage

// File: rtl/hta_ram.sv
module hta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hta_front.sv
module hta_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic [hta_pkg::ID_W-1:0]  req_handle_id,
   input  logic                      req_target_is_2d,
   output logic                      push_valid,
   input  logic                      push_ready,
   output hta_pkg::cmd_type          push_cmd
);
   import hta_pkg::*;

   logic    hold_valid_ff;
   logic    hold_valid_in;
   cmd_type hold_cmd_ff;
   cmd_type hold_cmd_in;
   logic    req_accept;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign req_accept = req_valid && req_ready;

   // Work out up front which transactions need the slot scan at all.
   always_comb begin
      hold_cmd_in.op       = op_type'(req_operation);
      hold_cmd_in.id       = req_handle_id;
      hold_cmd_in.id_zero  = (req_handle_id == '0);
      hold_cmd_in.bind_err = (hold_cmd_in.op == OP_BIND) && !req_target_is_2d;
      hold_cmd_in.scan     = (hold_cmd_in.op == OP_GENERATE) ||
                             (!hold_cmd_in.id_zero && !hold_cmd_in.bind_err);
   end

   always_comb begin
      if (req_accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         hold_cmd_ff <= hold_cmd_in;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_cmd   = hold_cmd_ff;

endmodule

// File: rtl/hta_queue.sv
module hta_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  hta_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output hta_pkg::cmd_type pop_cmd
);
   import hta_pkg::*;

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/hta_back.sv
module hta_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  hta_pkg::cmd_type          cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [hta_pkg::ID_W-1:0]  rsp_new_id,
   output logic                      rsp_present,
   output logic [hta_pkg::ID_W-1:0]  rsp_bound_now,
   output logic                      rsp_error_code
);
   import hta_pkg::*;

   state_type            state_ff;
   state_type            state_in;

   cmd_type              cmd_ff;
   cmd_type              cmd_in;
   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [TABLE_SLOTS-1:0] valid_in;
   logic [ID_W-1:0]      bound_ff;
   logic [ID_W-1:0]      bound_in;

   logic [CNT_W-1:0]     scan_cnt_ff;
   logic [CNT_W-1:0]     scan_cnt_in;
   logic                 rd_vld_ff;
   logic                 rd_last_ff;
   logic [SLOT_W-1:0]    rd_idx_ff;
   logic [ID_W-1:0]      rd_data;

   logic                 hit_ff;
   logic                 hit_in;
   logic [SLOT_W-1:0]    hit_slot_ff;
   logic [SLOT_W-1:0]    hit_slot_in;
   logic                 free_found_ff;
   logic                 free_found_in;
   logic [SLOT_W-1:0]    free_slot_ff;
   logic [SLOT_W-1:0]    free_slot_in;
   logic [USED_N-1:0]    used_ff;
   logic [USED_N-1:0]    used_in;
   logic [USED_IW-1:0]   pick_ff;
   logic [USED_IW-1:0]   pick_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [ID_W-1:0]      rsp_new_id_ff;
   logic [ID_W-1:0]      rsp_new_id_in;
   logic                 rsp_present_ff;
   logic                 rsp_present_in;
   logic [ID_W-1:0]      rsp_bound_ff;
   logic [ID_W-1:0]      rsp_bound_in;
   logic                 rsp_err_ff;
   logic                 rsp_err_in;

   logic                 out_free;
   logic                 take_cmd;
   logic                 issue;
   logic                 commit;
   logic                 slot_live;
   logic [ID_W-1:0]      gen_id;

   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr;
   logic [ID_W-1:0]      wr_data;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign gen_id   = ID_W'(pick_ff) + 1'b1;

   hta_ram #(
      .WIDTH (ID_W),
      .DEPTH (TABLE_SLOTS)
   ) u_handles (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (scan_cnt_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = cmd.scan ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff && rd_last_ff) begin
               state_in = (cmd_ff.op == OP_GENERATE) ? ST_PICK : ST_DONE;
            end
         end
         ST_PICK: begin
            if (!free_found_ff || !used_ff[pick_ff]) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      cmd_ready = 1'b0;
      issue     = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: cmd_ready = 1'b1;
         ST_SCAN: issue     = (scan_cnt_ff != CNT_W'(TABLE_SLOTS));
         ST_PICK: ;
         ST_DONE: commit    = out_free;
         default: ;
      endcase
   end

   assign take_cmd  = cmd_valid && cmd_ready;
   assign slot_live = rd_vld_ff && valid_ff[rd_idx_ff];

   // Scan bookkeeping and the final table update.
   always_comb begin
      cmd_in        = cmd_ff;
      scan_cnt_in   = scan_cnt_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      used_in       = used_ff;
      pick_in       = pick_ff;
      valid_in      = valid_ff;
      bound_in      = bound_ff;
      wr_en         = 1'b0;
      wr_addr       = free_slot_ff;
      wr_data       = cmd_ff.id;
      rsp_new_id_in  = rsp_new_id_ff;
      rsp_present_in = rsp_present_ff;
      rsp_bound_in   = rsp_bound_ff;
      rsp_err_in     = rsp_err_ff;

      if (take_cmd) begin
         cmd_in        = cmd;
         scan_cnt_in   = '0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
         used_in       = '0;
         pick_in       = '0;
      end

      if (issue) begin
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end

      // Compare stage: one slot per cycle, in ascending slot order.
      if (slot_live && (rd_data == cmd_ff.id)) begin
         hit_in      = 1'b1;
         hit_slot_in = rd_idx_ff;
      end
      if (rd_vld_ff && !valid_ff[rd_idx_ff] && !free_found_ff) begin
         free_found_in = 1'b1;
         free_slot_in  = rd_idx_ff;
      end
      for (int j = 0; j < USED_N; j++) begin
         if (slot_live && (rd_data == ID_W'(j + 1))) begin
            used_in[j] = 1'b1;
         end
      end

      if ((state_ff == ST_PICK) && free_found_ff && used_ff[pick_ff]) begin
         pick_in = pick_ff + 1'b1;
      end

      if (commit) begin
         rsp_new_id_in  = '0;
         rsp_present_in = 1'b0;
         rsp_err_in     = 1'b0;
         case (cmd_ff.op)
            OP_GENERATE: begin
               if (free_found_ff) begin
                  valid_in[free_slot_ff] = 1'b1;
                  wr_en                  = 1'b1;
                  wr_data                = gen_id;
                  rsp_new_id_in          = gen_id;
               end
            end
            OP_DELETE: begin
               if (hit_ff) begin
                  valid_in[hit_slot_ff] = 1'b0;
                  if (bound_ff == cmd_ff.id) begin
                     bound_in = '0;
                  end
               end
            end
            OP_BIND: begin
               if (cmd_ff.bind_err) begin
                  rsp_err_in = 1'b1;
               end else if (cmd_ff.id_zero) begin
                  bound_in = '0;
               end else if (hit_ff) begin
                  bound_in = cmd_ff.id;
               end else if (free_found_ff) begin
                  valid_in[free_slot_ff] = 1'b1;
                  wr_en                  = 1'b1;
                  bound_in               = cmd_ff.id;
               end
            end
            OP_QUERY: begin
               rsp_present_in = hit_ff;
            end
            default: ;
         endcase
         rsp_bound_in = bound_in;
      end
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         bound_ff      <= '0;
         scan_cnt_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         bound_ff      <= bound_in;
         scan_cnt_ff   <= scan_cnt_in;
         rd_vld_ff     <= issue;
         rd_last_ff    <= issue && (scan_cnt_ff == CNT_W'(TABLE_SLOTS - 1));
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      rd_idx_ff      <= scan_cnt_ff[SLOT_W-1:0];
      hit_slot_ff    <= hit_slot_in;
      free_slot_ff   <= free_slot_in;
      used_ff        <= used_in;
      pick_ff        <= pick_in;
      rsp_new_id_ff  <= rsp_new_id_in;
      rsp_present_ff <= rsp_present_in;
      rsp_bound_ff   <= rsp_bound_in;
      rsp_err_ff     <= rsp_err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_id     = rsp_new_id_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_bound_now  = rsp_bound_ff;
   assign rsp_error_code = rsp_err_ff;

   // A generated id must not already be held by a live slot.
   a_gen_id_free: assert property (@(posedge clock) disable iff (reset)
      (commit && (cmd_ff.op == OP_GENERATE) && free_found_ff) |-> !used_ff[pick_ff])
      else $error("generated id is already in use");

   // A recorded hit must still point at a live slot when the update lands.
   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && hit_ff) |-> valid_ff[hit_slot_ff])
      else $error("hit slot is not valid at commit");

   // Deleting the bound id leaves nothing bound to it.
   a_delete_unbinds: assert property (@(posedge clock) disable iff (reset)
      (commit && (cmd_ff.op == OP_DELETE) && hit_ff) |=> (bound_ff != $past(cmd_ff.id)))
      else $error("deleted id is still bound");

   // A nonzero binding always refers to some live slot.
   a_bound_has_slot: assert property (@(posedge clock) disable iff (reset)
      (bound_ff != '0) |-> (|valid_ff))
      else $error("bound id with an empty table");

endmodule

// File: rtl/handle_table_allocator.sv
// Handle table allocator. The block keeps a table of hta_pkg::TABLE_SLOTS
// object handle slots plus one bound id, and serves one request transaction
// at a time with exactly one response transaction: generate (the smallest
// free id of 1 or more, placed in the lowest free slot, 0 when the table is
// full), delete, bind to the 2D target (id 0 unbinds, any other target
// reports an invalid enum) and query. A front stage registers and classifies
// each request and hands it through a two-entry queue to the table engine,
// so a new request is taken while the engine is still busy. Requests that
// need no table lookup (a delete, bind or query of id 0, or a bind with a bad
// target) go straight from the idle state to the done state. Every other
// request walks the handle memory, which has one read port, one slot per
// cycle; a generate then steps through candidate ids one per cycle. The
// handle memory needs no clearing after reset: the slot valid bits are
// cleared at once, and an entry is only looked at while its valid bit is
// set.
module handle_table_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic [hta_pkg::ID_W-1:0]  req_handle_id,
   input  logic                      req_target_is_2d,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [hta_pkg::ID_W-1:0]  rsp_new_id,
   output logic                      rsp_present,
   output logic [hta_pkg::ID_W-1:0]  rsp_bound_now,
   output logic                      rsp_error_code
);
   import hta_pkg::*;

   // Front stage to queue.
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;

   // Queue to table engine.
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   hta_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_handle_id    (req_handle_id),
      .req_target_is_2d (req_target_is_2d),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_cmd         (push_cmd)
   );

   hta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // The engine owns the slot table, the binding and the response register.
   hta_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (pop_valid),
      .cmd_ready      (pop_ready),
      .cmd            (pop_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_id     (rsp_new_id),
      .rsp_present    (rsp_present),
      .rsp_bound_now  (rsp_bound_now),
      .rsp_error_code (rsp_error_code)
   );

endmodule
